>>> design/rect_union_bands_assert.svh
// Assertion macros for the rectangle union band pipeline.
// Used by the top level only; no other dependencies.
`ifndef RECT_UNION_BANDS_ASSERT_SVH
`define RECT_UNION_BANDS_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define RUB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define RUB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define RUB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`define RUB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> design/rub_pkg.sv
// Shared types for the rectangle union band pipeline.
// No dependencies.
package rub_pkg;

  localparam int InDataW  = 128;
  localparam int OutDataW = 72;

  typedef logic signed [16:0] coord_t;

  typedef struct packed {
    coord_t top;
    coord_t left;
    coord_t bot;
    coord_t right;
  } rect_t;

  typedef struct packed {
    rect_t a;
    rect_t b;
  } pair_t;

  typedef struct packed {
    logic   ne;
    coord_t top;
    coord_t bot;
    coord_t left;
    coord_t right;
  } band_t;

  typedef struct packed {
    logic            disj;
    band_t [2:0]     bd;
  } bandset_t;

  typedef struct packed {
    coord_t             top;
    logic signed [15:0] left;
    logic [15:0]        lines;
    logic [15:0]        cols;
  } res_t;

  typedef struct packed {
    logic [1:0]  cnt;
    res_t [2:0]  r;
  } grp_t;

endpackage

>>> design/rect_union_bands.sv
// Top level of the rectangle union band pipeline.
// Depends on rub_pkg, rub_front, rub_bands, rub_merge, rub_emit and the assert header.
//
//  channel  | ports             | word
//  ---------+-------------------+----------------------------------------
//  input    | in_tvalid/tready  | one rectangle pair
//  result   | out_tvalid/tready | one band, tlast on the final band
//
// A pair passes three register stages, then a band buffer, before its first
// band is offered. A pair sends one word per band (zero to three) on the
// result port, so the single result port sets the rate.
// Reset (rst_n low, synchronous) clears all valid bits and empties the band buffer.
// A stall on the result side backs up stage by stage; nothing is lost.
`include "rect_union_bands_assert.svh"

module rect_union_bands (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // a_top, a_left, a_lines, a_cols, b_top, b_left, b_lines, b_cols, pad
  input  logic [rub_pkg::InDataW-1:0]   in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // out_top, out_left, out_lines, out_cols, pad
  output logic [rub_pkg::OutDataW-1:0]  out_tdata,
  output logic                          out_tlast
);
  import rub_pkg::*;

  pair_t    pair;
  bandset_t bset;
  grp_t     grp;
  logic     s1_vld, s1_rdy, s2_vld, s2_rdy, s3_vld, s3_rdy;

  rub_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (in_tdata),
    .out_valid (s1_vld),
    .out_ready (s1_rdy),
    .out_pair  (pair)
  );

  rub_bands u_bands (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_vld),
    .in_ready  (s1_rdy),
    .in_pair   (pair),
    .out_valid (s2_vld),
    .out_ready (s2_rdy),
    .out_set   (bset)
  );

  rub_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_vld),
    .in_ready  (s2_rdy),
    .in_set    (bset),
    .out_valid (s3_vld),
    .out_ready (s3_rdy),
    .out_grp   (grp)
  );

  rub_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (s3_vld),
    .in_ready   (s3_rdy),
    .in_grp     (grp),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  `RUB_ASSERT_NXT(a_take_lands, clk, rst_n, in_tvalid && in_tready, s1_vld, "word lost")
  `RUB_ASSERT_NXT(a_s3_hold, clk, rst_n, s3_vld && !s3_rdy, s3_vld, "stalled group dropped")
  `RUB_ASSERT_IMP(a_idle_takes, clk, rst_n, !out_tvalid, s3_rdy, "idle buffer refuses")

endmodule

>>> design/rub_front.sv
// Stage 1: unpacks the input word and forms bottom and right edges.
// Depends on rub_pkg.
module rub_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rub_pkg::InDataW-1:0]   in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rub_pkg::pair_t                out_pair
);
  import rub_pkg::*;

  logic  vld_r;
  pair_t pair_r, pair_nxt;

  always_comb begin
    pair_nxt.a.top   = {in_data[15], in_data[15:0]};
    pair_nxt.a.left  = {in_data[31], in_data[31:16]};
    pair_nxt.a.bot   = pair_nxt.a.top + {2'b00, in_data[46:32]};
    pair_nxt.a.right = pair_nxt.a.left + {2'b00, in_data[61:47]};
    pair_nxt.b.top   = {in_data[77], in_data[77:62]};
    pair_nxt.b.left  = {in_data[93], in_data[93:78]};
    pair_nxt.b.bot   = pair_nxt.b.top + {2'b00, in_data[108:94]};
    pair_nxt.b.right = pair_nxt.b.left + {2'b00, in_data[123:109]};
  end

  assign in_ready  = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign out_pair  = pair_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pair_r <= pair_nxt;
    end
  end

endmodule

>>> design/rub_bands.sv
// Stage 2: touch test, row mark ordering and per-band column extents.
// Depends on rub_pkg.
module rub_bands (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rub_pkg::pair_t    in_pair,
  output logic              out_valid,
  input  logic              out_ready,
  output rub_pkg::bandset_t out_set
);
  import rub_pkg::*;

  logic     vld_r;
  bandset_t set_r, set_nxt;

  always_comb begin
    coord_t at, al, ab, ar, bt, bl, bb, br;
    coord_t m0, m1, m2, m3, t1, t2, lmin, rmax;
    coord_t mk [4];
    logic   in_a, in_b;
    at = in_pair.a.top;  al = in_pair.a.left;
    ab = in_pair.a.bot;  ar = in_pair.a.right;
    bt = in_pair.b.top;  bl = in_pair.b.left;
    bb = in_pair.b.bot;  br = in_pair.b.right;
    m0 = (at > bt) ? bt : at;
    t1 = (at > bt) ? at : bt;
    t2 = (ab > bb) ? bb : ab;
    m3 = (ab > bb) ? ab : bb;
    m1 = (t1 > t2) ? t2 : t1;
    m2 = (t1 > t2) ? t1 : t2;
    mk[0] = m0; mk[1] = m1; mk[2] = m2; mk[3] = m3;
    lmin = (al < bl) ? al : bl;
    rmax = (ar > br) ? ar : br;
    set_nxt.disj = (al > br) || (bl > ar) || (at > bb) || (bt > ab);
    for (int i = 0; i < 3; i++) begin
      in_a = (mk[i] >= at) && (mk[i+1] <= ab);
      in_b = (mk[i] >= bt) && (mk[i+1] <= bb);
      set_nxt.bd[i].ne  = (mk[i] != mk[i+1]);
      set_nxt.bd[i].top = mk[i];
      set_nxt.bd[i].bot = mk[i+1];
      if (in_a && in_b) begin
        set_nxt.bd[i].left  = lmin;
        set_nxt.bd[i].right = rmax;
      end else if (in_a) begin
        set_nxt.bd[i].left  = al;
        set_nxt.bd[i].right = ar;
      end else begin
        set_nxt.bd[i].left  = bl;
        set_nxt.bd[i].right = br;
      end
    end
    if (set_nxt.disj) begin
      set_nxt.bd[0] = {1'b1, at, ab, al, ar};
      set_nxt.bd[1] = {1'b1, bt, bb, bl, br};
      set_nxt.bd[2].ne = 1'b0;
    end
  end

  assign in_ready  = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign out_set   = set_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      set_r <= set_nxt;
    end
  end

endmodule

>>> design/rub_merge.sv
// Stage 3: drops empty bands, merges equal neighbors unless disjoint, forms sizes.
// Depends on rub_pkg.
module rub_merge (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rub_pkg::bandset_t in_set,
  output logic              out_valid,
  input  logic              out_ready,
  output rub_pkg::grp_t     out_grp
);
  import rub_pkg::*;

  logic vld_r;
  grp_t grp_r, grp_nxt;

  always_comb begin
    rect_t      cur [3];
    logic [1:0] n;
    logic [1:0] p;
    n = 2'd0;
    for (int k = 0; k < 3; k++) begin
      cur[k] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      p = n - 2'd1;
      if (in_set.bd[i].ne) begin
        if (n != 2'd0 && !in_set.disj && cur[p].left == in_set.bd[i].left &&
            cur[p].right == in_set.bd[i].right) begin
          cur[p].bot = in_set.bd[i].bot;
        end else if (n != 2'd3) begin
          cur[n].top   = in_set.bd[i].top;
          cur[n].left  = in_set.bd[i].left;
          cur[n].bot   = in_set.bd[i].bot;
          cur[n].right = in_set.bd[i].right;
          n = n + 2'd1;
        end
      end
    end
    grp_nxt.cnt = n;
    for (int k = 0; k < 3; k++) begin
      grp_nxt.r[k].top   = cur[k].top;
      grp_nxt.r[k].left  = cur[k].left[15:0];
      grp_nxt.r[k].lines = 16'(cur[k].bot - cur[k].top);
      grp_nxt.r[k].cols  = 16'(cur[k].right - cur[k].left);
    end
  end

  assign in_ready  = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign out_grp   = grp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      grp_r <= grp_nxt;
    end
  end

endmodule

>>> design/rub_emit.sv
// Output stage: holds one union's bands and sends them one word a cycle while out_tready is high.
// Depends on rub_pkg.
module rub_emit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rub_pkg::grp_t                 in_grp,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [rub_pkg::OutDataW-1:0]  out_tdata,
  output logic                          out_tlast
);
  import rub_pkg::*;

  grp_t       grp_r;
  logic [1:0] idx_r, idx_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       busy_r, busy_nxt;
  logic       last, load;
  res_t       cur;

  assign last     = (idx_r == cnt_r - 2'd1);
  assign in_ready = !busy_r || (out_tready && last);
  assign load     = in_valid && in_ready;

  always_comb begin
    idx_nxt  = idx_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (load) begin
      idx_nxt  = 2'd0;
      cnt_nxt  = in_grp.cnt;
      busy_nxt = (in_grp.cnt != 2'd0);
    end else if (busy_r && out_tready) begin
      idx_nxt = idx_r + 2'd1;
      if (last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= 2'd0;
      cnt_r  <= 2'd0;
      busy_r <= 1'b0;
    end else begin
      idx_r  <= idx_nxt;
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_r <= in_grp;
    end
  end

  assign cur        = grp_r.r[idx_r];
  assign out_tvalid = busy_r;
  assign out_tlast  = last;
  assign out_tdata  = {7'b0, cur.cols, cur.lines, cur.left, cur.top};

endmodule
